FILE: rtl/dse_pkg.sv
// Shared types, constants and event tables of the debounced sensor edge event block.
package dse_pkg;

  localparam int TIMER_BITS = 10;
  localparam int WIN_W      = 10;
  localparam int CMP_W      = (TIMER_BITS > WIN_W) ? TIMER_BITS : WIN_W;
  localparam int NUM_EVENTS = 12;
  localparam int IDX_W      = 4;
  localparam int SENSOR_W   = 16;
  localparam int ACTION_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int ESTOP_POS  = 15;

  typedef logic [TIMER_BITS-1:0] cnt_t;
  typedef logic [WIN_W-1:0]      win_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [IDX_W-1:0]      idx_t;

  localparam cnt_t CNT_MAX = {TIMER_BITS{1'b1}};

  localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GENERAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESTOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH  = 2'd2;

  localparam win_t GENERAL_RST = 10'd40;
  localparam win_t ESTOP_RST   = 10'd750;
  localparam win_t SWITCH_RST  = 10'd100;

  typedef enum logic [1:0] {
    WIN_ZERO,
    WIN_GENERAL,
    WIN_ESTOP,
    WIN_SWITCH
  } win_sel_e;

  // Sensor bit watched by each event, in table order.
  localparam idx_t EV_BIT [NUM_EVENTS] = '{
    4'd12, 4'd13, 4'd14, 4'd15, 4'd0, 4'd1, 4'd3, 4'd6, 4'd7, 4'd2, 4'd4, 4'd5
  };

  localparam win_sel_e EV_WIN [NUM_EVENTS] = '{
    WIN_GENERAL, WIN_GENERAL, WIN_GENERAL, WIN_ESTOP,
    WIN_GENERAL, WIN_ZERO, WIN_ZERO, WIN_ZERO, WIN_GENERAL,
    WIN_ZERO, WIN_ZERO, WIN_SWITCH
  };

  typedef struct packed {
    logic sample;
    logic tick;
    logic shift;
  } dse_ctrl_t;

  typedef struct packed {
    logic vld;
    idx_t idx;
    logic lvl;
  } dse_link_t;

endpackage

FILE: rtl/dse_intf.sv
// Handshake channel interfaces for sensor items, events and register writes.
interface dse_in_if;
  logic                             valid;
  logic                             ready;
  logic [dse_pkg::ACTION_W-1:0]     action;
  logic [dse_pkg::SENSOR_W-1:0]     sensors;
  modport source (output valid, output action, output sensors, input ready);
  modport sink (input valid, input action, input sensors, output ready);
endinterface

interface dse_out_if;
  logic                         valid;
  logic                         ready;
  logic [dse_pkg::IDX_W-1:0]    event_index;
  logic                         new_level;
  logic                         last;
  modport source (output valid, output event_index, output new_level, output last,
                  input ready);
  modport sink (input valid, input event_index, input new_level, input last,
                output ready);
endinterface

interface dse_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dse_pkg::CFG_IDX_W-1:0]  index;
  logic [dse_pkg::WIN_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/debounced_sensor_edge_events.sv
// Top level of the debounced sensor edge event block.
//
// Items arrive on in_i: a sample, a millisecond tick, a load of the stored
// levels or a clear of the emergency stop bit. Lockout windows are written
// on cfg_i, which is always ready. Events leave on out_o in table order,
// one per transfer, with last set on the final event of a sample.
// A sample is decided in the cycle it is accepted: the counters of fired
// events are zeroed, the stored levels are updated at once if any event
// fires, and the fired events enter a chain of twelve cells that shifts
// one place per cycle toward the output register. in_i is not ready while
// the chain holds events; ticks, loads, clears and samples that fire
// nothing leave it ready. When the receiver stalls, the chain stops
// shifting once its head holds an event, and input stays blocked until the
// last event of the sample sits in the output register. Reset saturates
// all counters, clears the stored levels and empties the chain, and
// restores the default windows.
module debounced_sensor_edge_events (
  input  logic  clk_i,
  input  logic  rst_ni,
  dse_in_if.sink    in_i,
  dse_out_if.source out_o,
  dse_cfg_if.sink   cfg_i
);

  localparam int N = dse_pkg::NUM_EVENTS;

  dse_pkg::win_t      general_q, estop_q, switch_q;
  logic [dse_pkg::SENSOR_W-1:0] stored_q;
  dse_pkg::dse_ctrl_t ctrl;
  dse_pkg::dse_link_t link [N+1];
  logic [N:0]         any;
  logic [N-1:0]       fire;
  dse_pkg::win_t      win [N];
  logic [dse_pkg::SENSOR_W-1:0] chg;
  logic               in_acc, busy, out_free;
  logic               out_vld_q;
  dse_pkg::idx_t      out_idx_q;
  logic               out_lvl_q, out_last_q;

  assign in_acc   = in_i.valid && in_i.ready;
  assign busy     = any[0];
  assign in_i.ready = !busy;
  assign out_free = !out_vld_q || out_o.ready;
  assign chg      = in_i.sensors ^ stored_q;

  assign ctrl.sample = in_acc && (in_i.action == dse_pkg::ACT_SAMPLE);
  assign ctrl.tick   = in_acc && (in_i.action == dse_pkg::ACT_TICK);
  assign ctrl.shift  = busy && (!link[0].vld || out_free);

  assign link[N] = '0;
  assign any[N]  = 1'b0;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      unique case (dse_pkg::EV_WIN[i])
        dse_pkg::WIN_GENERAL: win[i] = general_q;
        dse_pkg::WIN_ESTOP:   win[i] = estop_q;
        dse_pkg::WIN_SWITCH:  win[i] = switch_q;
        default:              win[i] = '0;
      endcase
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    dse_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .idx_i  (dse_pkg::idx_t'(g)),
      .chg_i  (chg[dse_pkg::EV_BIT[g]]),
      .lvl_i  (in_i.sensors[dse_pkg::EV_BIT[g]]),
      .win_i  (win[g]),
      .link_i (link[g+1]),
      .any_i  (any[g+1]),
      .link_o (link[g]),
      .any_o  (any[g]),
      .fire_o (fire[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      general_q <= dse_pkg::GENERAL_RST;
      estop_q   <= dse_pkg::ESTOP_RST;
      switch_q  <= dse_pkg::SWITCH_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        dse_pkg::CFG_GENERAL: general_q <= cfg_i.data;
        dse_pkg::CFG_ESTOP:   estop_q   <= cfg_i.data;
        dse_pkg::CFG_SWITCH:  switch_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= '0;
    end else if (in_acc) begin
      unique case (in_i.action)
        dse_pkg::ACT_SAMPLE: if (|fire) stored_q <= in_i.sensors;
        dse_pkg::ACT_LOAD:   stored_q <= in_i.sensors;
        dse_pkg::ACT_CLEAR:  stored_q[dse_pkg::ESTOP_POS] <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl.shift && link[0].vld) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.shift && link[0].vld) begin
      out_idx_q  <= link[0].idx;
      out_lvl_q  <= link[0].lvl;
      out_last_q <= !any[1];
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.event_index = out_idx_q;
  assign out_o.new_level   = out_lvl_q;
  assign out_o.last        = out_last_q;

endmodule

FILE: rtl/dse_cell.sv
// One event cell: lockout counter, firing test and one stage of the event shift chain.
module dse_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dse_pkg::dse_ctrl_t  ctrl_i,
  input  dse_pkg::idx_t       idx_i,
  input  logic                chg_i,
  input  logic                lvl_i,
  input  dse_pkg::win_t       win_i,
  input  dse_pkg::dse_link_t  link_i,
  input  logic                any_i,
  output dse_pkg::dse_link_t  link_o,
  output logic                any_o,
  output logic                fire_o
);

  dse_pkg::cnt_t      cnt_q, cnt_d;
  dse_pkg::dse_link_t link_q, link_d;
  logic               open_win;

  assign open_win = dse_pkg::cmp_t'(cnt_q) > dse_pkg::cmp_t'(win_i);
  assign fire_o   = ctrl_i.sample && chg_i && open_win;

  always_comb begin
    cnt_d = cnt_q;
    if (fire_o) begin
      cnt_d = '0;
    end else if (ctrl_i.tick && (cnt_q != dse_pkg::CNT_MAX)) begin
      cnt_d = cnt_q + dse_pkg::cnt_t'(1);
    end
  end

  always_comb begin
    link_d = link_q;
    if (ctrl_i.sample) begin
      link_d.vld = fire_o;
      link_d.idx = idx_i;
      link_d.lvl = lvl_i;
    end else if (ctrl_i.shift) begin
      link_d = link_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= dse_pkg::CNT_MAX;
      link_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      link_q <= link_d;
    end
  end

  assign link_o = link_q;
  assign any_o  = link_q.vld || any_i;

endmodule

FILE: rtl/dse_checker.sv
// Port-level checks of the debounced sensor edge event block and their binding.
module dse_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [dse_pkg::ACTION_W-1:0]      in_action_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [dse_pkg::IDX_W-1:0]         out_index_i,
  input  logic                              out_level_i,
  input  logic                              out_last_i
);

  // Only a sample can produce events, so other actions leave the input open.
  a_no_block_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i != dse_pkg::ACT_SAMPLE) |=> in_ready_i)
    else $error("input blocked after an action that produces no events");

  // Later events of the same sample are still queued behind a non-final event.
  a_block_until_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input accepted while a sample still has events queued");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_index_i < dse_pkg::idx_t'(dse_pkg::NUM_EVENTS)))
    else $error("event index out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_index_i) && $stable(out_level_i) && $stable(out_last_i))
    else $error("stalled event changed before its transfer");

endmodule

bind debounced_sensor_edge_events dse_checker u_dse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_index_i (out_o.event_index),
  .out_level_i (out_o.new_level),
  .out_last_i  (out_o.last)
);
